// ===== design/batch_exchange_sorter_top_defines.svh =====
// ---------------------------------------------------------------------------
// Batch exchange sorter assertion macros
// Shared concurrent assertion forms used by the sorter's top level.
// ---------------------------------------------------------------------------
`ifndef BATCH_EXCHANGE_SORTER_TOP_DEFINES_SVH
`define BATCH_EXCHANGE_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define BES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter assertion failed: next-cycle check");

`endif

// ===== design/bes_pkg.sv =====
// ---------------------------------------------------------------------------
// Batch exchange sorter package
// Sizes, types and register codes shared by the sorter's files.
// ---------------------------------------------------------------------------
package bes_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index, taken from paddr[2] (byte address 4*i).
    localparam logic REG_DESCENDING = 1'b0;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    typedef struct packed {
        logic load;   // a new element is inserted this cycle
        logic shift;  // the row moves one place towards cell 0
        logic desc;   // descending order selected
    } cell_ctrl_t;

endpackage

// ===== design/bes_if.sv =====
// ---------------------------------------------------------------------------
// Batch exchange sorter stream interfaces
// Valid/ready channels for batch elements in and sorted elements out.
// ---------------------------------------------------------------------------
interface bes_in_if import bes_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t sample_in;
    logic   last_item;

    modport source (output valid, output sample_in, output last_item, input ready);
    modport sink   (input valid, input sample_in, input last_item, output ready);
endinterface

interface bes_out_if import bes_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   last_out;
    logic   overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

// ===== design/batch_exchange_sorter_top.sv =====
// ---------------------------------------------------------------------------
// Batch exchange sorter
// Sorts a batch of signed Q16.16 values with a row of insertion cells.
// ---------------------------------------------------------------------------
// The sorter takes one batch element per cycle on the input channel and keeps
// the row of DEPTH cells in sorted order as it loads: every cell compares the
// new element with the value it holds, and the cells from the insertion point
// upwards each take their neighbour's value in the same cycle, so the row is
// sorted again as each element is taken. The transfer that carries last_item
// ends the load; from the next cycle the batch leaves from cell 0, one result
// per cycle while the output side is ready, the row moving one place towards
// cell 0 on each output transfer. During this unload the input channel is held
// off (ready low). Elements beyond DEPTH are dropped and every result of that
// batch carries overflow. The direction register (byte address 0, bit 0)
// selects ascending (0) or descending (1) order; the user must write it only
// while the block is idle, as the block itself does not enforce this. No
// clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`include "batch_exchange_sorter_top_defines.svh"

module batch_exchange_sorter_top
    import bes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bes_in_if.sink                in_ch,
    bes_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Control state: how many cells hold data, whether the row is unloading,
    // and whether the current batch lost elements.
    cnt_t count_reg;
    cnt_t count_next;
    logic drain_reg;
    logic drain_next;
    logic dropped_reg;
    logic dropped_next;

    logic       descending;
    logic       in_xfer;
    logic       out_xfer;
    logic       full;
    cell_ctrl_t ctrl;

    value_t           cell_value [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_take;

    bes_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .descending (descending)
    );

    // Input is taken only while loading; the output side is fed straight from
    // cell 0, which is itself a register.
    assign in_ch.ready = !drain_reg;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;
    assign full        = (count_reg == CNT_W'(DEPTH));

    assign ctrl.load  = in_xfer && !full;
    assign ctrl.shift = out_xfer;
    assign ctrl.desc  = descending;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic   l_take;
            value_t l_value;
            logic   l_valid;
            value_t r_value;
            logic   r_valid;

            if (gi == 0)
            begin : g_first
                assign l_take  = 1'b0;
                assign l_value = '0;
                assign l_valid = 1'b0;
            end
            else
            begin : g_mid
                assign l_take  = cell_take[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_value = cell_value[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            bes_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .sample      (in_ch.sample_in),
                .left_take   (l_take),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .right_value (r_value),
                .right_valid (r_valid),
                .take        (cell_take[gi]),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (in_xfer)
        begin
            if (full)
                dropped_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
            if (in_ch.last_item)
                drain_next = 1'b1;
        end
        if (out_xfer)
        begin
            count_next = count_reg - 1'b1;
            // The final result of the batch closes it and starts the next one.
            if (count_reg == CNT_W'(1))
            begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

    assign out_ch.valid        = drain_reg;
    assign out_ch.sorted_value = cell_value[0];
    assign out_ch.last_out     = (count_reg == CNT_W'(1));
    assign out_ch.overflow     = dropped_reg;

    // The occupied cells always form one run that matches the fill count.
    `BES_ASSERT_IMP(a_count_matches_cells, 1'b1, $countones(cell_valid) == int'(count_reg))
    // A result is only offered from an occupied head cell.
    `BES_ASSERT_IMP(a_head_valid_on_output, out_ch.valid, cell_valid[0] && count_reg != '0)
    // The final result's transfer empties the row and reopens the input.
    `BES_ASSERT_NEXT(a_last_ends_batch, out_xfer && out_ch.last_out,
                     !out_ch.valid && count_reg == '0 && !dropped_reg)

endmodule

// ===== design/bes_cell.sv =====
// ---------------------------------------------------------------------------
// Batch exchange sorter cell
// One slot of the sorted row: insert with shift-up, or shift down to unload.
// ---------------------------------------------------------------------------
module bes_cell
    import bes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     sample,
    input  logic       left_take,
    input  value_t     left_value,
    input  logic       left_valid,
    input  value_t     right_value,
    input  logic       right_valid,
    output logic       take,
    output value_t     value,
    output logic       valid
);

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;

    // The new element belongs at or before this slot.
    assign take = !valid_reg || (ctrl.desc ? (sample > value_reg) : (sample < value_reg));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.load && take)
        begin
            if (left_take)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = sample;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== design/bes_apb_regs.sv =====
// ---------------------------------------------------------------------------
// Batch exchange sorter register block
// APB-style access to the sort direction register.
// ---------------------------------------------------------------------------
module bes_apb_regs
    import bes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  descending
);

    logic desc_reg;
    logic desc_next;
    logic hit_desc;

    assign pready   = 1'b1;
    assign hit_desc = (paddr[2] == REG_DESCENDING);

    always_comb
    begin
        desc_next = desc_reg;
        if (psel && penable && pwrite && hit_desc)
            desc_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desc_reg <= 1'b0;
        else
            desc_reg <= desc_next;
    end

    assign prdata     = hit_desc ? {{(APB_DATA_W-1){1'b0}}, desc_reg} : '0;
    assign descending = desc_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Batch exchange sorter testbench
// Streams batches of signed values into the sorter, sets the direction
// register between phases and checks every sorted result against a
// predicted copy of the batch, field by field and in order.
// ---------------------------------------------------------------------------

module tb;
    import bes_pkg::*;

    // One expected sorted element, as it should leave the output channel.
    typedef struct {
        value_t value;
        logic   last;
        logic   ovf;
    } sorted_rec_t;

    // Keeps the batch being loaded and the sorted elements still owed by the
    // block. Order among equal values cannot be seen, so a plain exchange sort
    // of the held values gives the exact expected sequence.
    class sort_scoreboard;
        value_t      batch[$];
        bit          dropped;
        bit          desc;
        sorted_rec_t pending[$];
        int          errors;

        function void note_input(value_t v, logic l);
            value_t      row[$];
            value_t      t;
            sorted_rec_t rec;
            bit          swap;
            if (batch.size() < DEPTH)
                batch.push_back(v);
            else
                dropped = 1'b1;
            if (l)
            begin
                row = batch;
                for (int i = 0; i + 1 < row.size(); i++)
                begin
                    for (int j = i + 1; j < row.size(); j++)
                    begin
                        swap = desc ? (row[j] > row[i]) : (row[j] < row[i]);
                        if (swap)
                        begin
                            t      = row[i];
                            row[i] = row[j];
                            row[j] = t;
                        end
                    end
                end
                foreach (row[k])
                begin
                    rec.value = row[k];
                    rec.last  = (k == row.size() - 1);
                    rec.ovf   = dropped;
                    pending.push_back(rec);
                end
                batch.delete();
                dropped = 1'b0;
            end
        endfunction

        function void check_result(value_t v, logic l, logic o);
            sorted_rec_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%b overflow=%b",
                         $time, v, l, o);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (v !== want.value)
            begin
                $display("%0t: sorted_value expected %0d actual %0d", $time, want.value, v);
                errors++;
            end
            if (l !== want.last)
            begin
                $display("%0t: last_out expected %b actual %b", $time, want.last, l);
                errors++;
            end
            if (o !== want.ovf)
            begin
                $display("%0t: overflow expected %b actual %b", $time, want.ovf, o);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // When clear, neither side inserts idle cycles: this gives a long stretch
    // of back-to-back transfers on both channels.
    bit             gaps_on;
    sort_scoreboard book;

    bes_in_if  in_ch ();
    bes_out_if out_ch ();

    batch_exchange_sorter_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // The output side: every transfer seen at a rising edge is checked, and
    // ready is redrawn for the next cycle. Ready is held low with a chance of
    // roughly 18 in a hundred while gaps are enabled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                book.check_result(out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
        end
        out_ch.ready <= !(gaps_on && ($urandom_range(99) < 18));
    end

    // Writes the direction register, then reads it back. Each APB transfer is a
    // setup phase followed by an access phase; pready is waited for, although
    // the block always holds it high.
    task automatic write_direction(input logic [APB_DATA_W-1:0] data);
        logic [APB_ADDR_W-1:0] addr;
        addr = '0;
        addr[2] = REG_DESCENDING;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        book.desc = data[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[0] !== data[0])
        begin
            $display("%0t: direction read back expected %b actual %b",
                     $time, data[0], prdata[0]);
            book.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one element and returns at the edge where the transfer happens.
    // Valid is left high so that the next call can follow without a gap; the
    // caller lowers it when a run of items ends.
    task automatic send_item(input value_t v, input logic l);
        while (gaps_on && ($urandom_range(99) < 18))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= v;
        in_ch.last_item <= l;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        book.note_input(v, l);
    endtask

    // Values lean towards the two extremes and towards a narrow band around
    // zero, so that ties and sign crossings turn up often; the rest are drawn
    // over the whole 32-bit range.
    function automatic value_t pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return value_t'(32'h8000_0000);
        else if (r < 16)
            return value_t'(32'h7FFF_FFFF);
        else if (r < 40)
            return value_t'($signed($urandom_range(8)) - 4);
        else
            return value_t'($urandom);
    endfunction

    task automatic send_batch(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // Lets the block finish unloading before the direction is changed. All
    // results owed must have arrived; a few spare cycles follow before the
    // register is touched.
    task automatic wait_until_idle();
        in_ch.valid <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int len;
        book    = new();
        gaps_on = 1'b1;
        rst_n   = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.last_item <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, ascending order as left by reset. A batch of one
        // element, a batch holding both extremes, zero and values either side
        // of it, and a batch full of ties.
        send_item(value_t'(32'h8000_0000), 1'b1);
        send_item(value_t'(32'h7FFF_FFFF), 1'b0);
        send_item(value_t'(32'h8000_0000), 1'b0);
        send_item(value_t'(0), 1'b0);
        send_item(value_t'(-1), 1'b0);
        send_item(value_t'(1), 1'b0);
        send_item(value_t'(32'h0001_0000), 1'b1);
        send_item(value_t'(5), 1'b0);
        send_item(value_t'(5), 1'b0);
        send_item(value_t'(-5), 1'b0);
        send_item(value_t'(5), 1'b1);
        wait_until_idle();

        // Descending order, with the upper data bits set to show that only
        // bit 0 of the register counts.
        write_direction(32'hFFFF_FFFF);
        send_item(value_t'(32'h7FFF_FFFF), 1'b0);
        send_item(value_t'(32'h8000_0000), 1'b0);
        send_item(value_t'(0), 1'b0);
        send_item(value_t'(-1), 1'b0);
        send_item(value_t'(1), 1'b0);
        send_item(value_t'(32'h0001_0000), 1'b1);
        send_item(value_t'(32'h7FFF_FFFF), 1'b1);
        wait_until_idle();

        // Random phases. Each opens with a batch at or beyond the store depth:
        // exactly full, then with extra items dropped including the last one,
        // then one item over. The third phase runs with no idle cycles on either side.
        for (int p = 0; p < 4; p++)
        begin
            write_direction({31'($urandom_range(32'h7FFF_FFFF)), 1'(p % 2 == 0)});
            gaps_on = (p != 2);
            len  = (p == 0) ? DEPTH : (p == 1) ? DEPTH + 2 : DEPTH + 1;
            sent = len;
            send_batch(len);
            while (sent < 76)
            begin
                if ($urandom_range(99) < 6)
                    len = DEPTH + $urandom_range(4);
                else
                    len = $urandom_range(1, 12);
                send_batch(len);
                sent += len;
            end
            wait_until_idle();
        end

        gaps_on = 1'b1;
        repeat (20) @(posedge clk);
        if (book.errors == 0 && book.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
